/* rtl/core/avva_pkg.sv */
package avva_pkg;

   // Table geometry
   localparam int MAX_STATES  = 16;
   localparam int MAX_NODES   = 64;
   localparam int STATE_IDX_W = $clog2(MAX_STATES);
   localparam int NODE_IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int ADDR_W      = NODE_IDX_W + STATE_IDX_W;
   localparam int MEM_DEPTH   = 1 << ADDR_W;

   // Field widths
   localparam int NODE_FIELD_W  = 6;
   localparam int STATE_FIELD_W = 4;
   localparam int ALPHA_W       = 32;
   localparam int BELIEF_W      = 17;
   localparam int REWARD_W      = 40;
   localparam int BEST_NODE_W   = 6;
   localparam int NUM_STATES_W  = 5;
   localparam int NUM_NODES_W   = 7;

   // Datapath widths: signed alpha times zero-extended belief, summed over all states
   localparam int PROD_W = ALPHA_W + BELIEF_W + 1;
   localparam int ACC_W  = PROD_W + STATE_IDX_W;
   localparam int FRAC_W = 16;

   localparam logic signed [REWARD_W-1:0] REWARD_MAX = {1'b0, {(REWARD_W-1){1'b1}}};
   localparam logic signed [REWARD_W-1:0] REWARD_MIN = {1'b1, {(REWARD_W-1){1'b0}}};

   // Command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Register port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_STATES = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_NODES  = 8'd1;
   localparam logic [NUM_STATES_W-1:0] NUM_STATES_RST = 5'd16;
   localparam logic [NUM_NODES_W-1:0]  NUM_NODES_RST  = 7'd64;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_BELIEF,
      CMD_EVAL
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type                op;
      logic                      store;
      logic [NODE_IDX_W-1:0]     node;
      logic [STATE_IDX_W-1:0]    state;
      logic [ALPHA_W-1:0]        alpha;
      logic [BELIEF_W-1:0]       belief;
   } cmd_type;

   typedef struct packed {
      logic [STATE_IDX_W-1:0] state_last;
      logic [NODE_IDX_W-1:0]  node_last;
   } cfg_type;

   typedef struct packed {
      logic busy;
   } bk_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_DRAIN
   } bk_state_type;

endpackage

/* rtl/core/avva_if.sv */
interface avva_req_if import avva_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [NODE_FIELD_W-1:0]   node_index;
   logic [STATE_FIELD_W-1:0]  state_index;
   logic signed [ALPHA_W-1:0] alpha_value;
   logic [BELIEF_W-1:0]       belief_value;
   logic                      last_element;

   modport source (output valid, req_type, node_index, state_index, alpha_value,
                   belief_value, last_element, input ready);
   modport sink   (input valid, req_type, node_index, state_index, alpha_value,
                   belief_value, last_element, output ready);
endinterface

interface avva_rsp_if import avva_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [REWARD_W-1:0] best_reward;
   logic [BEST_NODE_W-1:0]     best_node;

   modport source (output valid, best_reward, best_node, input ready);
   modport sink   (input valid, best_reward, best_node, output ready);
endinterface

interface avva_csr_if import avva_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/alpha_vector_value_argmax.sv */
// Alpha-vector value with argmax.
// req_ch carries load items (req_type 0) that write one alpha entry of the
// table, and belief items (req_type 1) that write one belief element. A belief
// item with last_element set starts an evaluation: the dot product of the
// stored belief with every alpha vector in use, and one transfer on rsp_ch with
// the largest value (rounded to Q24.16, saturated) and the first node reaching it.
// csr_ch writes num_states (index 0) and num_nodes (index 1); the user must
// write them only while idle, as the block does not enforce it. Load and
// belief items are taken one per cycle while the command queue has room. An
// evaluation holds the single multiply-accumulate unit while it walks every
// node by every state (one alpha memory read a cycle), and the back end takes
// no further command until the result is loaded into the output register.
// A two-entry command queue lets requests keep arriving while an evaluation runs.
// Reset clears the control state and sets num_states to 16 and num_nodes to
// 64; the alpha table and belief buffer hold nothing until written.
// If the receiver stalls, the result is held in the output register; the next
// evaluation runs and then waits for that register to empty.
module alpha_vector_value_argmax import avva_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   avva_req_if.sink   req_ch,
   avva_rsp_if.source rsp_ch,
   avva_csr_if.sink   csr_ch
);

   logic [NUM_STATES_W-1:0] num_states_ff;
   logic [NUM_NODES_W-1:0]  num_nodes_ff;
   cfg_type                 cfg;
   logic                    q_push_valid;
   logic                    q_push_ready;
   cmd_type                 q_push_cmd;
   logic                    q_pop_valid;
   logic                    q_pop_ready;
   cmd_type                 q_pop_cmd;
   bk_status_type           bk_status;

   // Register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff <= NUM_STATES_RST;
         num_nodes_ff  <= NUM_NODES_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_NUM_STATES: num_states_ff <= NUM_STATES_W'(csr_ch.data);
            CSR_NUM_NODES:  num_nodes_ff  <= NUM_NODES_W'(csr_ch.data);
            default: ;
         endcase
      end
   end

   // Clamp counts into range and turn them into last indices
   always_comb begin
      if (num_states_ff == '0) begin
         cfg.state_last = '0;
      end else if (int'(num_states_ff) > MAX_STATES) begin
         cfg.state_last = STATE_IDX_W'(MAX_STATES - 1);
      end else begin
         cfg.state_last = STATE_IDX_W'(num_states_ff - 1'b1);
      end
      if (num_nodes_ff == '0) begin
         cfg.node_last = '0;
      end else if (int'(num_nodes_ff) > MAX_NODES) begin
         cfg.node_last = NODE_IDX_W'(MAX_NODES - 1);
      end else begin
         cfg.node_last = NODE_IDX_W'(num_nodes_ff - 1'b1);
      end
   end

   avva_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_cmd   (q_push_cmd)
   );

   avva_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_cmd   (q_push_cmd),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_cmd    (q_pop_cmd)
   );

   avva_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_cmd   (q_pop_cmd),
      .rsp_ch    (rsp_ch),
      .status    (bk_status)
   );

`ifndef SYNTHESIS
   // An accepted request reaches the queue input on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> q_push_valid)
      else $error("accepted request did not reach the command queue");

   // No command is drained while an evaluation is in progress
   assert property (@(posedge clock) disable iff (reset)
      bk_status.busy |-> !q_pop_ready)
      else $error("command queue drained during an evaluation");

   // A result only appears at the end of an evaluation
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(bk_status.busy))
      else $error("result raised without an evaluation");
`endif

endmodule

/* rtl/core/avva_front.sv */
module avva_front import avva_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   avva_req_if.sink  req_ch,
   output logic      push_valid,
   input  logic      push_ready,
   output cmd_type   push_cmd
);

   logic    cmd_valid_ff, cmd_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    req_xfer;
   logic    node_ok;
   logic    state_ok;

   // Take a new request whenever the holding register is empty or drains this cycle
   assign req_ch.ready = !cmd_valid_ff || push_ready;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // Classify the request and check table bounds
   always_comb begin
      node_ok  = int'(req_ch.node_index) < MAX_NODES;
      state_ok = int'(req_ch.state_index) < MAX_STATES;

      cmd_in.op     = CMD_LOAD;
      if (req_ch.req_type) begin
         cmd_in.op = req_ch.last_element ? CMD_EVAL : CMD_BELIEF;
      end
      cmd_in.store  = state_ok && (req_ch.req_type || node_ok);
      cmd_in.node   = NODE_IDX_W'(req_ch.node_index);
      cmd_in.state  = STATE_IDX_W'(req_ch.state_index);
      cmd_in.alpha  = req_ch.alpha_value;
      cmd_in.belief = req_ch.belief_value;

      cmd_valid_in = cmd_valid_ff;
      if (push_ready) begin
         cmd_valid_in = 1'b0;
      end
      if (req_xfer) begin
         cmd_valid_in = 1'b1;
      end
   end

   // Hold valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   // Capture payload on transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff <= cmd_in;
      end
   end

   assign push_valid = cmd_valid_ff;
   assign push_cmd   = cmd_ff;

endmodule

/* rtl/core/avva_queue.sv */
module avva_queue import avva_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam logic [QPTR_W:0]   FULL_COUNT = (QPTR_W+1)'(QUEUE_DEPTH);
   localparam logic [QPTR_W-1:0] LAST_PTR   = QPTR_W'(QUEUE_DEPTH - 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push_xfer;
   logic              pop_xfer;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push_xfer  = push_valid && push_ready;
   assign pop_xfer   = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_xfer) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_xfer) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_xfer && !pop_xfer) begin
         count_in = count_ff + 1'b1;
      end else if (pop_xfer && !push_xfer) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (push_xfer) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/avva_back.sv */
module avva_back import avva_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  cmd_type       pop_cmd,
   avva_rsp_if.source    rsp_ch,
   output bk_status_type status
);

   localparam logic signed [ACC_W:0] HALF_LSB =
      {{(ACC_W+1-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

   // Storage
   logic [ALPHA_W-1:0]  alpha_mem [MEM_DEPTH];
   logic [BELIEF_W-1:0] belief_ff [MAX_STATES];

   // Sequencer
   bk_state_type           state_ff, state_in;
   logic [NODE_IDX_W-1:0]  node_cnt_ff, node_cnt_in;
   logic [STATE_IDX_W-1:0] st_cnt_ff, st_cnt_in;
   logic                   issue;
   logic                   load_rsp;
   logic                   start_eval;
   logic                   pop_xfer;
   logic                   rsp_free;

   // Read stage
   logic                   p1_valid_ff;
   logic                   p1_first_ff;
   logic                   p1_last_s_ff;
   logic [NODE_IDX_W-1:0]  p1_node_ff;
   logic [STATE_IDX_W-1:0] p1_st_ff;
   logic [ALPHA_W-1:0]     rdata_ff;

   // Multiply stage
   logic                     p2_valid_ff;
   logic                     p2_first_ff;
   logic                     p2_last_s_ff;
   logic [NODE_IDX_W-1:0]    p2_node_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // Accumulate and compare
   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_base;
   logic                    sum_valid_ff;
   logic [NODE_IDX_W-1:0]   sum_node_ff;
   logic signed [ACC_W-1:0] best_ff;
   logic [NODE_IDX_W-1:0]   best_node_ff;
   logic                    best_valid_ff;
   logic                    better;
   logic                    done_ff;

   // Output
   logic                       rsp_valid_ff;
   logic signed [REWARD_W-1:0] rsp_reward_ff, rsp_reward_in;
   logic [BEST_NODE_W-1:0]     rsp_node_ff;
   logic signed [ACC_W:0]      rnd_sum;
   logic signed [ACC_W:0]      rnd_q;

   assign pop_xfer    = pop_valid && pop_ready;
   assign start_eval  = pop_xfer && (pop_cmd.op == CMD_EVAL);
   assign rsp_free    = !rsp_valid_ff || rsp_ch.ready;
   assign status.busy = state_ff != BK_IDLE;

   // Next state: pop commands when idle, walk nodes by states, then wait for the last sum and a free output register
   always_comb begin
      state_in    = state_ff;
      node_cnt_in = node_cnt_ff;
      st_cnt_in   = st_cnt_ff;
      pop_ready   = 1'b0;
      issue       = 1'b0;
      load_rsp    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid && pop_cmd.op == CMD_EVAL) begin
               state_in    = BK_RUN;
               node_cnt_in = '0;
               st_cnt_in   = '0;
            end
         end
         BK_RUN: begin
            issue = 1'b1;
            if (st_cnt_ff == cfg.state_last) begin
               st_cnt_in = '0;
               if (node_cnt_ff == cfg.node_last) begin
                  state_in = BK_DRAIN;
               end else begin
                  node_cnt_in = node_cnt_ff + 1'b1;
               end
            end else begin
               st_cnt_in = st_cnt_ff + 1'b1;
            end
         end
         BK_DRAIN: begin
            if (done_ff && rsp_free) begin
               load_rsp = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      node_cnt_ff <= node_cnt_in;
      st_cnt_ff   <= st_cnt_in;
   end

   // Write alpha entries, read one per cycle during a walk
   always_ff @(posedge clock) begin
      if (pop_xfer && pop_cmd.op == CMD_LOAD && pop_cmd.store) begin
         alpha_mem[{pop_cmd.node, pop_cmd.state}] <= pop_cmd.alpha;
      end
      if (issue) begin
         rdata_ff <= alpha_mem[{node_cnt_ff, st_cnt_ff}];
      end
   end

   // Write belief elements
   always_ff @(posedge clock) begin
      if (pop_xfer && pop_cmd.op != CMD_LOAD && pop_cmd.store) begin
         belief_ff[pop_cmd.state] <= pop_cmd.belief;
      end
   end

   // Multiply, accumulate, compare
   always_comb begin
      prod_in  = $signed(rdata_ff) * $signed({1'b0, belief_ff[p1_st_ff]});
      acc_base = p2_first_ff ? '0 : acc_ff;
      acc_in   = acc_base + ACC_W'(prod_ff);
      better   = !best_valid_ff || (acc_ff > best_ff);
   end

   // Pipeline valid flags and completion
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         sum_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         p1_valid_ff  <= issue;
         p2_valid_ff  <= p1_valid_ff;
         sum_valid_ff <= p2_valid_ff && p2_last_s_ff;
         if (start_eval) begin
            best_valid_ff <= 1'b0;
         end else if (sum_valid_ff) begin
            best_valid_ff <= 1'b1;
         end
         if (load_rsp) begin
            done_ff <= 1'b0;
         end else if (sum_valid_ff && sum_node_ff == cfg.node_last) begin
            done_ff <= 1'b1;
         end
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      p1_first_ff  <= st_cnt_ff == '0;
      p1_last_s_ff <= st_cnt_ff == cfg.state_last;
      p1_node_ff   <= node_cnt_ff;
      p1_st_ff     <= st_cnt_ff;
      p2_first_ff  <= p1_first_ff;
      p2_last_s_ff <= p1_last_s_ff;
      p2_node_ff   <= p1_node_ff;
      prod_ff      <= prod_in;
      sum_node_ff  <= p2_node_ff;
      if (p2_valid_ff) begin
         acc_ff <= acc_in;
      end
      // keep the first node that reaches the maximum
      if (sum_valid_ff && better) begin
         best_ff      <= acc_ff;
         best_node_ff <= sum_node_ff;
      end
   end

   // Round half up to 16 fraction bits, then saturate
   always_comb begin
      rnd_sum = (ACC_W+1)'(best_ff) + HALF_LSB;
      rnd_q   = rnd_sum >>> FRAC_W;
      if (rnd_q > (ACC_W+1)'(REWARD_MAX)) begin
         rsp_reward_in = REWARD_MAX;
      end else if (rnd_q < (ACC_W+1)'(REWARD_MIN)) begin
         rsp_reward_in = REWARD_MIN;
      end else begin
         rsp_reward_in = REWARD_W'(rnd_q);
      end
   end

   // Output register: hold until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_reward_ff <= rsp_reward_in;
         rsp_node_ff   <= BEST_NODE_W'(best_node_ff);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.best_reward = rsp_reward_ff;
   assign rsp_ch.best_node   = rsp_node_ff;

endmodule
